FILE: design/affine_matrix_inverse_top_defines.svh
// Assertion helpers used by ami_back.
`ifndef AFFINE_MATRIX_INVERSE_TOP_DEFINES_SVH
`define AFFINE_MATRIX_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define AMI_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ami: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define AMI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ami: check failed");

`endif

FILE: design/ami_pkg.sv
`default_nettype none

package ami_pkg;

  localparam int NUM_ELEM  = 12;
  localparam int NUM_COF   = 9;
  localparam int NUM_STEPS = 42;

  localparam logic [3:0] DST_DET  = 4'd9;
  localparam logic [3:0] DST_ACC0 = 4'd10;
  localparam logic [3:0] DST_ACC2 = 4'd12;

  // one multiply-accumulate step of the front sequencer
  typedef struct packed {
    logic [3:0] a_idx;
    logic       b_cof;
    logic [3:0] b_idx;
    logic       b_hi;
    logic       neg;
    logic       clr;
    logic       wr;
    logic [3:0] dst;
  } step_t;

  typedef step_t [NUM_STEPS-1:0] prog_t;

  function automatic prog_t build_prog();
    prog_t p;
    step_t st;
    int s;
    int r1, r2, c1, c2;
    p = '0;
    s = 0;
    // cofactors: two products each
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r1 = (r == 2) ? 0 : r + 1;
        r2 = (r == 0) ? 2 : r - 1;
        c1 = (c == 2) ? 0 : c + 1;
        c2 = (c == 0) ? 2 : c - 1;
        st = '0;
        st.a_idx = 4'(r1 * 4 + c1);
        st.b_idx = 4'(r2 * 4 + c2);
        st.clr   = 1'b1;
        p[s] = st;
        s++;
        st = '0;
        st.a_idx = 4'(r1 * 4 + c2);
        st.b_idx = 4'(r2 * 4 + c1);
        st.neg   = 1'b1;
        st.wr    = 1'b1;
        st.dst   = 4'(r * 3 + c);
        p[s] = st;
        s++;
      end
    end
    // determinant along row 0, cofactor split in low and high halves
    for (int c = 0; c < 3; c++) begin
      for (int h = 0; h < 2; h++) begin
        st = '0;
        st.a_idx = 4'(c);
        st.b_cof = 1'b1;
        st.b_idx = 4'(c);
        st.b_hi  = 1'(h);
        st.clr   = (c == 0 && h == 0);
        st.wr    = (c == 2 && h == 1);
        st.dst   = DST_DET;
        p[s] = st;
        s++;
      end
    end
    // adjugate times translation, one sum per inverse row
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int h = 0; h < 2; h++) begin
          st = '0;
          st.a_idx = 4'(j * 4 + 3);
          st.b_cof = 1'b1;
          st.b_idx = 4'(j * 3 + i);
          st.b_hi  = 1'(h);
          st.clr   = (j == 0 && h == 0);
          st.wr    = (j == 2 && h == 1);
          st.dst   = 4'(DST_ACC0 + 4'(i));
          p[s] = st;
          s++;
        end
      end
    end
    return p;
  endfunction

  localparam prog_t PROG = build_prog();

endpackage

`default_nettype wire

FILE: design/affine_matrix_inverse_top.sv
// Affine transform inverse, signed fixed point (FRAC_BITS fraction bits).
// Input channel: in_valid_i/in_ready_o carry one 3x4 transform (linear part
// plus translation column). Output channel: out_valid_o/out_ready_i carry
// the three rows of the inverse, row_index 0, 1, 2, last_row on row 2.
// The front runs a 42-step multiply-accumulate program on one signed
// (ENTRY_WIDTH+1)-bit multiplier: cofactors, determinant and the
// adjugate-times-translation sums. A two-entry queue hands the results
// to the back, where four restoring dividers produce one row at a time,
// one quotient bit per cycle; these dividers set the throughput.
// A one-entry input buffer takes the next transform while the front works.
// When the receiver stalls, a finished row waits in the output register,
// the back then the queue and front fill and finally in_ready_o drops.
// A zero determinant gives three rows with singular set and zero entries.
// Reset empties the buffer, the queue and the output register.
`default_nettype none

module affine_matrix_inverse_top #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [ENTRY_WIDTH-1:0] lin_00_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_01_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_02_i,
  input  logic signed [ENTRY_WIDTH-1:0] shift_0_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_10_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_11_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_12_i,
  input  logic signed [ENTRY_WIDTH-1:0] shift_1_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_20_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_21_i,
  input  logic signed [ENTRY_WIDTH-1:0] lin_22_i,
  input  logic signed [ENTRY_WIDTH-1:0] shift_2_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0] row_index_o,
  output logic signed [ENTRY_WIDTH-1:0] out_c0_o,
  output logic signed [ENTRY_WIDTH-1:0] out_c1_o,
  output logic signed [ENTRY_WIDTH-1:0] out_c2_o,
  output logic signed [ENTRY_WIDTH-1:0] out_shift_o,
  output logic singular_o,
  output logic last_row_o
);

  localparam int EW = ENTRY_WIDTH;
  localparam int CW = 2 * EW + 1;
  localparam int AW = 3 * EW + 3;
  localparam int JW = ami_pkg::NUM_COF * CW + 4 * AW;

  logic [ami_pkg::NUM_ELEM-1:0][EW-1:0] elem;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  logic [ami_pkg::NUM_COF-1:0][CW-1:0] fj_cof, bj_cof;
  logic [AW-1:0] fj_det, bj_det;
  logic [2:0][AW-1:0] fj_tacc, bj_tacc;

  assign elem = {shift_2_i, lin_22_i, lin_21_i, lin_20_i,
                 shift_1_i, lin_12_i, lin_11_i, lin_10_i,
                 shift_0_i, lin_02_i, lin_01_i, lin_00_i};

  ami_front #(.EW(EW), .CW(CW), .AW(AW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .elem_i     (elem),
    .job_valid_o(fj_valid),
    .job_ready_i(fj_ready),
    .job_cof_o  (fj_cof),
    .job_det_o  (fj_det),
    .job_tacc_o (fj_tacc)
  );

  ami_fifo #(.W(JW), .DEPTH(2)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fj_valid),
    .wr_ready_o(fj_ready),
    .wr_data_i ({fj_cof, fj_det, fj_tacc}),
    .rd_valid_o(bj_valid),
    .rd_ready_i(bj_ready),
    .rd_data_o ({bj_cof, bj_det, bj_tacc})
  );

  ami_back #(.EW(EW), .F(FRAC_BITS), .CW(CW), .AW(AW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(bj_valid),
    .job_ready_o(bj_ready),
    .job_cof_i  (bj_cof),
    .job_det_i  (bj_det),
    .job_tacc_i (bj_tacc),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .row_index_o(row_index_o),
    .out_c0_o   (out_c0_o),
    .out_c1_o   (out_c1_o),
    .out_c2_o   (out_c2_o),
    .out_shift_o(out_shift_o),
    .singular_o (singular_o),
    .last_row_o (last_row_o)
  );

endmodule

`default_nettype wire

FILE: design/ami_front.sv
`default_nettype none

module ami_front #(
  parameter int EW = 32,
  parameter int CW = 65,
  parameter int AW = 99
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [ami_pkg::NUM_ELEM-1:0][EW-1:0] elem_i,
  output logic job_valid_o,
  input  logic job_ready_i,
  output logic [ami_pkg::NUM_COF-1:0][CW-1:0] job_cof_o,
  output logic [AW-1:0] job_det_o,
  output logic [2:0][AW-1:0] job_tacc_o
);

  logic [ami_pkg::NUM_ELEM-1:0][EW-1:0] buf_q, ma_q, mb_q;
  logic buf_full_q, run_q, opv_q, done_q;
  logic [5:0] step_q;
  ami_pkg::step_t cur_op, op_q;
  logic signed [EW:0] opa, opb;
  logic signed [2*EW+1:0] prod_q;
  logic signed [AW-1:0] acc_q, acc_d, acc_base, term;
  logic [ami_pkg::NUM_COF-1:0][CW-1:0] cof_q;
  logic [AW-1:0] det_q;
  logic [2:0][AW-1:0] tacc_q;
  logic start;

  assign in_ready_o  = !buf_full_q;
  assign start       = buf_full_q && !run_q && !opv_q && !done_q;
  assign job_valid_o = done_q;
  assign job_cof_o   = cof_q;
  assign job_det_o   = det_q;
  assign job_tacc_o  = tacc_q;

  always_comb begin
    cur_op = ami_pkg::PROG[step_q];
    opa = signed'({ma_q[cur_op.a_idx][EW-1], ma_q[cur_op.a_idx]});
    if (!cur_op.b_cof) begin
      opb = signed'({mb_q[cur_op.b_idx][EW-1], mb_q[cur_op.b_idx]});
    end else if (cur_op.b_hi) begin
      opb = signed'(cof_q[cur_op.b_idx][CW-1:EW]);
    end else begin
      opb = signed'({1'b0, cof_q[cur_op.b_idx][EW-1:0]});
    end
  end

  always_comb begin
    term = AW'(prod_q);
    if (op_q.b_hi) begin
      term = term <<< EW;
    end
    acc_base = op_q.clr ? '0 : acc_q;
    acc_d = op_q.neg ? acc_base - term : acc_base + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_full_q <= 1'b0;
      run_q      <= 1'b0;
      step_q     <= '0;
      opv_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        buf_full_q <= 1'b1;
      end else if (start) begin
        buf_full_q <= 1'b0;
      end
      if (start) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == 6'(ami_pkg::NUM_STEPS - 1)) begin
          run_q  <= 1'b0;
          step_q <= '0;
        end else begin
          step_q <= step_q + 6'd1;
        end
      end
      opv_q <= run_q;
      if (opv_q && op_q.wr && op_q.dst == ami_pkg::DST_ACC2) begin
        done_q <= 1'b1;
      end else if (job_valid_o && job_ready_i) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      buf_q <= elem_i;
    end
    if (start) begin
      ma_q <= buf_q;
      mb_q <= buf_q;
    end
    if (run_q) begin
      prod_q <= opa * opb;
      op_q   <= cur_op;
    end
    if (opv_q) begin
      acc_q <= acc_d;
      if (op_q.wr) begin
        if (op_q.dst < ami_pkg::DST_DET) begin
          cof_q[op_q.dst] <= acc_d[CW-1:0];
        end else if (op_q.dst == ami_pkg::DST_DET) begin
          det_q <= acc_d;
        end else begin
          tacc_q[2'(op_q.dst - ami_pkg::DST_ACC0)] <= acc_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/ami_fifo.sv
`default_nettype none

module ami_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0] mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CNW-1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q != CNW'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/ami_div.sv
`default_nettype none

module ami_div #(
  parameter int NIW = 133,
  parameter int DW  = 99,
  parameter int QW  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [NIW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic busy_o,
  output logic [QW-1:0] quo_o
);

  localparam int NW   = ((NIW > DW) ? NIW : DW) + 2;
  localparam int DDW  = DW + 1;
  localparam int CMPW = ((NW > DDW + QW) ? NW : DDW + QW) + 1;
  localparam int CNTW = $clog2(QW + 1);

  logic [NIW-1:0] mag_n;
  logic [DW-1:0] mag_d;
  logic [NW-1:0] n_ext;
  logic [DDW-1:0] d_ext;
  logic sat_c;
  logic run_q, neg_q, sat_q;
  logic [CNTW-1:0] cnt_q;
  logic [DDW-1:0] rem_q, d_q;
  logic [QW-1:0] low_q, quo_q, limit, mag;
  logic [DDW:0] trial;
  logic take;

  // rounded magnitude: floor((2|n| + |d|) / (2|d|))
  always_comb begin
    mag_n = num_i[NIW-1] ? NIW'(-num_i) : NIW'(num_i);
    mag_d = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    n_ext = (NW'(mag_n) << 1) + NW'(mag_d);
    d_ext = DDW'(mag_d) << 1;
    sat_c = CMPW'(n_ext) >= (CMPW'(d_ext) << QW);
    trial = {rem_q, low_q[QW-1]};
    take  = trial >= {1'b0, d_q};
    limit = neg_q ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
    mag   = (sat_q || quo_q > limit) ? limit : quo_q;
    quo_o = neg_q ? QW'(-mag) : mag;
  end

  assign busy_o = run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= !sat_c;
      cnt_q <= CNTW'(QW);
    end else if (run_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      run_q <= cnt_q != CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NIW-1] ^ den_i[DW-1];
      sat_q <= sat_c;
      d_q   <= d_ext;
      rem_q <= DDW'(n_ext >> QW);
      low_q <= n_ext[QW-1:0];
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= take ? DDW'(trial - {1'b0, d_q}) : trial[DDW-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[QW-2:0], take};
    end
  end

endmodule

`default_nettype wire

FILE: design/ami_back.sv
`default_nettype none
`include "affine_matrix_inverse_top_defines.svh"

module ami_back #(
  parameter int EW = 32,
  parameter int F  = 16,
  parameter int CW = 65,
  parameter int AW = 99
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  logic [ami_pkg::NUM_COF-1:0][CW-1:0] job_cof_i,
  input  logic [AW-1:0] job_det_i,
  input  logic [2:0][AW-1:0] job_tacc_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0] row_index_o,
  output logic signed [EW-1:0] out_c0_o,
  output logic signed [EW-1:0] out_c1_o,
  output logic signed [EW-1:0] out_c2_o,
  output logic signed [EW-1:0] out_shift_o,
  output logic singular_o,
  output logic last_row_o
);

  localparam int NIW = AW + 2 * F;

  logic busy_q, start_q, pend_q, sing_q;
  logic [1:0] row_q;
  logic [ami_pkg::NUM_COF-1:0][CW-1:0] cof_q;
  logic [AW-1:0] det_q;
  logic [2:0][AW-1:0] tacc_q;
  logic [3:0][NIW-1:0] num;
  logic [3:0][EW-1:0] quo;
  logic [3:0] dbusy;
  logic res_rdy, out_free, load, advance;

  // column of the current row always sits at positions 0, 3, 6
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = NIW'(signed'(cof_q[j * 3])) <<< (2 * F);
    end
    num[3] = NIW'(-signed'(tacc_q[0])) <<< F;
  end

  for (genvar k = 0; k < 4; k++) begin : g_div
    ami_div #(.NIW(NIW), .DW(AW), .QW(EW)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(start_q),
      .num_i  (signed'(num[k])),
      .den_i  (signed'(det_q)),
      .busy_o (dbusy[k]),
      .quo_o  (quo[k])
    );
  end

  assign job_ready_o = !busy_q;
  assign load     = job_valid_i && job_ready_o;
  assign res_rdy  = pend_q && !start_q && (dbusy == '0);
  assign out_free = !out_valid_o || out_ready_i;
  assign advance  = res_rdy && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      pend_q      <= 1'b0;
      row_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (load) begin
        busy_q  <= 1'b1;
        row_q   <= '0;
        start_q <= 1'b1;
        pend_q  <= 1'b1;
      end
      if (advance) begin
        out_valid_o <= 1'b1;
        if (row_q == 2'd2) begin
          busy_q <= 1'b0;
          pend_q <= 1'b0;
        end else begin
          row_q   <= row_q + 2'd1;
          start_q <= 1'b1;
        end
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cof_q  <= job_cof_i;
      det_q  <= job_det_i;
      tacc_q <= job_tacc_i;
      sing_q <= job_det_i == '0;
    end else if (advance) begin
      for (int j = 0; j < 3; j++) begin
        cof_q[j * 3]     <= cof_q[j * 3 + 1];
        cof_q[j * 3 + 1] <= cof_q[j * 3 + 2];
      end
      tacc_q[0] <= tacc_q[1];
      tacc_q[1] <= tacc_q[2];
    end
    if (advance) begin
      row_index_o <= row_q;
      last_row_o  <= row_q == 2'd2;
      singular_o  <= sing_q;
      out_c0_o    <= sing_q ? '0 : signed'(quo[0]);
      out_c1_o    <= sing_q ? '0 : signed'(quo[1]);
      out_c2_o    <= sing_q ? '0 : signed'(quo[2]);
      out_shift_o <= sing_q ? '0 : signed'(quo[3]);
    end
  end

  `AMI_ASSERT_IMPL(a_sing_zero, out_valid_o && singular_o, {out_c0_o, out_c1_o, out_c2_o, out_shift_o} == '0)
  `AMI_ASSERT_IMPL(a_last_row, out_valid_o, last_row_o == (row_index_o == 2'd2))
  `AMI_ASSERT_IMPL(a_row_more, out_valid_o && !last_row_o, busy_q)

endmodule

`default_nettype wire

FILE: sim/affine_matrix_inverse_top_tb.sv
`timescale 1ns / 100ps

module affine_matrix_inverse_top_tb;

  localparam int EW = 32;
  localparam int FB = 16;

  typedef logic signed [191:0] wide_t;
  typedef logic [11:0][EW-1:0] xform_t;

  typedef struct {
    logic [1:0]    row_index;
    logic [EW-1:0] c0;
    logic [EW-1:0] c1;
    logic [EW-1:0] c2;
    logic [EW-1:0] shift;
    logic          singular;
    logic          last_row;
  } inv_row_t;

  class inverse_scoreboard;
    inv_row_t pending_rows[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function wide_t entry(xform_t x, int idx);
      logic signed [EW-1:0] v;
      v = x[idx];
      return wide_t'(v);
    endfunction

    // round to nearest, ties away from zero, saturated to EW bits
    function logic [EW-1:0] div_round(wide_t num, wide_t den);
      wide_t n, d, q, lim;
      logic  neg;
      neg = num[191] ^ den[191];
      n = num[191] ? -num : num;
      d = den[191] ? -den : den;
      q = (2 * n + d) / (2 * d);
      lim = neg ? (wide_t'(1) <<< (EW - 1)) : (wide_t'(1) <<< (EW - 1)) - 1;
      if (q > lim) q = lim;
      return neg ? -q[EW-1:0] : q[EW-1:0];
    endfunction

    function void note_transform(xform_t x);
      wide_t    m[3][3], t[3], cof[3][3], det, acc;
      inv_row_t row;
      int       r1, r2, c1, c2;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) m[r][c] = entry(x, r * 4 + c);
        t[r] = entry(x, r * 4 + 3);
      end
      for (int r = 0; r < 3; r++) begin
        r1 = (r + 1) % 3;
        r2 = (r + 2) % 3;
        for (int c = 0; c < 3; c++) begin
          c1 = (c + 1) % 3;
          c2 = (c + 2) % 3;
          cof[r][c] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
        end
      end
      det = m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2];
      for (int i = 0; i < 3; i++) begin
        row.row_index = 2'(i);
        row.last_row  = (i == 2);
        row.singular  = (det == 0);
        if (det == 0) begin
          row.c0 = '0;
          row.c1 = '0;
          row.c2 = '0;
          row.shift = '0;
        end else begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc = acc + cof[j][i] * t[j];
          row.c0 = div_round(cof[0][i] <<< (2 * FB), det);
          row.c1 = div_round(cof[1][i] <<< (2 * FB), det);
          row.c2 = div_round(cof[2][i] <<< (2 * FB), det);
          row.shift = div_round((-acc) <<< FB, det);
        end
        pending_rows.push_back(row);
      end
    endfunction

    function void report(string what, logic [EW-1:0] got, logic [EW-1:0] want);
      $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
      errors++;
    endfunction

    function void check_row(inv_row_t got);
      inv_row_t want;
      if (pending_rows.size() == 0) begin
        report("unexpected row, row_index", EW'(got.row_index), '0);
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_index !== want.row_index)
        report("row_index", EW'(got.row_index), EW'(want.row_index));
      if (got.c0 !== want.c0) report("out_c0", got.c0, want.c0);
      if (got.c1 !== want.c1) report("out_c1", got.c1, want.c1);
      if (got.c2 !== want.c2) report("out_c2", got.c2, want.c2);
      if (got.shift !== want.shift) report("out_shift", got.shift, want.shift);
      if (got.singular !== want.singular)
        report("singular", EW'(got.singular), EW'(want.singular));
      if (got.last_row !== want.last_row)
        report("last_row", EW'(got.last_row), EW'(want.last_row));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_ready_i = 1'b0;
  logic out_valid_o;
  xform_t xf = '0;
  logic [1:0] row_index_o;
  logic signed [EW-1:0] out_c0_o, out_c1_o, out_c2_o, out_shift_o;
  logic singular_o, last_row_o;

  int idle_pct = 0;
  int stall_pct = 0;

  inverse_scoreboard sb = new();

  affine_matrix_inverse_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .lin_00_i(xf[0]), .lin_01_i(xf[1]), .lin_02_i(xf[2]), .shift_0_i(xf[3]),
    .lin_10_i(xf[4]), .lin_11_i(xf[5]), .lin_12_i(xf[6]), .shift_1_i(xf[7]),
    .lin_20_i(xf[8]), .lin_21_i(xf[9]), .lin_22_i(xf[10]), .shift_2_i(xf[11]),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .row_index_o(row_index_o), .out_c0_o(out_c0_o), .out_c1_o(out_c1_o),
    .out_c2_o(out_c2_o), .out_shift_o(out_shift_o),
    .singular_o(singular_o), .last_row_o(last_row_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    inv_row_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.row_index = row_index_o;
      got.c0 = out_c0_o;
      got.c1 = out_c1_o;
      got.c2 = out_c2_o;
      got.shift = out_shift_o;
      got.singular = singular_o;
      got.last_row = last_row_o;
      sb.check_row(got);
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_transform(xform_t x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    xf <= x;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transform(x);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [EW-1:0] srand(int mag);
    return EW'($signed($urandom_range(2 * mag)) - mag);
  endfunction

  function automatic xform_t rand_transform();
    xform_t x;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 12; i++) x[i] = $urandom;
    if (kind < 5) begin
      // well-conditioned: near-unit diagonal, small off-diagonal
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          x[r * 4 + c] = (r == c) ? EW'(65536) + srand(49152) : srand(20000);
    end else if (kind < 7) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) x[r * 4 + c] = srand(1 << ($urandom_range(20) + 1));
    end else if (kind == 7) begin
      // duplicated row: singular
      for (int c = 0; c < 3; c++) x[8 + c] = x[c];
    end
    return x;
  endfunction

  function automatic xform_t diag(logic [EW-1:0] d, logic [EW-1:0] off, logic [EW-1:0] t);
    xform_t x;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) x[r * 4 + c] = (r == c) ? d : off;
      x[r * 4 + 3] = t;
    end
    return x;
  endfunction

  initial begin
    xform_t x;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, zero, extremes, saturation, ties and rotations
    send_transform(diag(32'h0001_0000, '0, '0));
    send_transform(diag(32'h0001_0000, '0, 32'h0003_8000));
    send_transform(diag('0, '0, 32'h1234_5678));
    send_transform(diag(32'h7fff_ffff, '0, 32'h7fff_ffff));
    send_transform(diag(32'h8000_0000, '0, 32'h8000_0000));
    send_transform(diag(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_transform(diag(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_transform(diag(32'h0000_0001, '0, 32'h0000_0001));
    send_transform(diag(32'hffff_ffff, '0, 32'h7fff_ffff));
    send_transform(diag(32'h0002_0000, '0, 32'h0000_0001));
    send_transform(diag(32'h0003_0000, '0, 32'h0000_0003));
    send_transform(diag(32'hfffe_0000, 32'h0000_8000, 32'hffff_ffff));
    send_transform(diag(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    x = diag('0, '0, 32'h0001_0000);
    x[1] = 32'hffff_0000; x[4] = 32'h0001_0000; x[10] = 32'h0001_0000;
    send_transform(x);
    x = diag(32'h0000_b505, '0, 32'h0010_0000);
    x[1] = 32'hffff_4afb; x[4] = 32'h0000_b505; x[10] = 32'h0001_0000;
    send_transform(x);
    x = diag(32'h0001_0000, 32'h0001_0000, 32'h5555_5555);
    send_transform(x);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 11 : 81) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 11 : 81) : 0;
      for (int n = 0; n < 62; n++) send_transform(rand_transform());
      // hold off until every row of this phase has come back
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rows.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
